FILE: src/koc_pkg.sv
`default_nettype none
package koc_pkg;

	typedef enum logic [1:0] {
		OP_ACCUM = 2'd0,
		OP_DRAIN = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic [3:0] COMBOS_RESET = 4'd8;

	// classified command handed from front to back
	typedef enum logic [1:0] {
		K_ACCUM = 2'd0,
		K_DRAIN = 2'd1,
		K_CLEAR = 2'd2,
		K_BAD   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  combination_index;
		logic [63:0] hash_key;
		logic [31:0] amount;
	} item_t;

	typedef struct packed {
		logic [31:0] entry_count;
		logic        last_entry;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  idx;
		logic [63:0] key;
		logic [31:0] amount;
	} cmd_t;

endpackage
`default_nettype wire

FILE: src/keyed_occurrence_counter.sv
// Channel   Handshake            Payload                      Direction
// request   push / full          item (item_t)                in
// result    empty / pop          result (result_t)            out
// config    cfg_write            combinations_in_use [3:0]    in
//
// Requests are classified in the front and queued (2 deep) for the sequencer.
// Steps per request, paced by the single registered read port of the tables:
//   accumulate: accept, read and compare each slot probed (SRD, SCMP), then
//   shift each later slot (SHRD, SHWR) and insert (INS), or update a hit (HIT).
//   drain: DRD, DOUT per entry; clear, bad index, empty drain: accept only.
// Reset zeroes the fill counts at once; no clearing pass, no wait after reset.
// Either side may stall; results wait in a 2-deep output queue.
`default_nettype none
module keyed_occurrence_counter import koc_pkg::*; #(
	parameter int COMBINATIONS = 8,
	parameter int ENTRIES      = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_write,
	input  wire logic [3:0] combinations_in_use
);
	// front -> command queue
	logic    cmd_push, cmd_pop, cmd_empty;
	cmd_t    cmd_in, cmd_out;
	// back -> result queue
	logic    res_push, res_full;
	result_t res_in;

	koc_front #(.COMBINATIONS(COMBINATIONS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cfg_write(cfg_write), .cfg_data(combinations_in_use),
		.cmd_push(cmd_push), .cmd(cmd_in)
	);

	koc_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .wr(cmd_push), .wdata(cmd_in), .full(full),
		.rd(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
	);

	koc_back #(
		.COMBINATIONS(COMBINATIONS), .ENTRIES(ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(cmd_empty), .cmd(cmd_out),
		.cmd_pop(cmd_pop), .out_full(res_full), .out_push(res_push),
		.out_data(res_in)
	);

	koc_fifo #(.W($bits(result_t)), .DEPTH(2)) u_resq (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .wdata(res_in),
		.full(res_full), .rd(pop), .rdata(result), .empty(empty)
	);
endmodule
`default_nettype wire

FILE: src/koc_fifo.sv
`default_nettype none
module koc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         rd,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/koc_front.sv
`default_nettype none
module koc_front import koc_pkg::*; #(
	parameter int COMBINATIONS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       full,
	input  wire item_t      item,
	input  wire logic       cfg_write,
	input  wire logic [3:0] cfg_data,
	output logic            cmd_push,
	output cmd_t            cmd
);
	logic [3:0] combos_q;
	logic       idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combos_q <= COMBOS_RESET;
		end else if (cfg_write) begin
			combos_q <= cfg_data;
		end
	end

	// index valid below min(register, table count)
	assign idx_ok = ({1'b0, item.combination_index} < combos_q) &&
			(32'(item.combination_index) < COMBINATIONS);

	always_comb begin
		cmd.idx    = item.combination_index;
		cmd.key    = item.hash_key;
		cmd.amount = item.amount;
		cmd.kind   = K_BAD;
		cmd_push   = push && !full;
		case (item.opcode)
			OP_CLEAR: cmd.kind = K_CLEAR;
			OP_ACCUM: cmd.kind = idx_ok ? K_ACCUM : K_BAD;
			OP_DRAIN: cmd.kind = idx_ok ? K_DRAIN : K_BAD;
			default:  cmd_push = 1'b0; // unused opcode, dropped
		endcase
	end
endmodule
`default_nettype wire

FILE: src/koc_back.sv
`default_nettype none
module koc_back import koc_pkg::*; #(
	parameter int COMBINATIONS = 8,
	parameter int ENTRIES      = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_empty,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	input  wire logic out_full,
	output logic      out_push,
	output result_t   out_data
);
	localparam int SLOTS = COMBINATIONS * ENTRIES;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW    = (COMBINATIONS > 1) ? $clog2(COMBINATIONS) : 1;
	localparam int FW    = $clog2(ENTRIES + 1);
	localparam int SUMW  = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		IDLE, DRD, DOUT, SRD, SCMP, HIT, MISS, SHRD, SHWR, INS
	} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [31:0]            b
	);
		logic [SUMW-1:0] s;
		s = SUMW'(a) + SUMW'(b);
		return (s > SUMW'(CMAX)) ? CMAX : s[COUNT_WIDTH-1:0];
	endfunction

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [TW-1:0]          tbl_q;
	logic [SW-1:0]          base_q;
	logic [FW-1:0]          fill_q [COMBINATIONS];
	logic [FW-1:0]          fcur_q, pos_q, i_q;

	logic [63:0]            key_mem [SLOTS];
	logic [COUNT_WIDTH-1:0] cnt_mem [SLOTS];
	logic [63:0]            key_rd_q;
	logic [COUNT_WIDTH-1:0] cnt_rd_q;

	logic                   rd_en, wr_en;
	logic [SW-1:0]          rd_addr, wr_addr;
	logic [63:0]            wr_key;
	logic [COUNT_WIDTH-1:0] wr_cnt, new_cnt;
	logic [TW-1:0]          tbl_in;
	logic [FW-1:0]          fill_in;

	assign tbl_in  = TW'(cmd.idx);
	assign fill_in = fill_q[tbl_in];
	assign new_cnt = sat_add((state_q == HIT) ? cnt_rd_q : '0, cmd_q.amount);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			cnt_rd_q <= cnt_mem[rd_addr];
		end
	end

	always_comb begin
		cmd_pop  = 1'b0;
		out_push = 1'b0;
		out_data = '{entry_count: '0, last_entry: 1'b1, status: ST_OK};
		rd_en    = 1'b0;
		rd_addr  = base_q + SW'(pos_q);
		wr_en    = 1'b0;
		wr_addr  = base_q + SW'(pos_q);
		wr_key   = key_rd_q;
		wr_cnt   = new_cnt;
		case (state_q)
			IDLE: begin
				cmd_pop = !cmd_empty && !out_full;
				if (cmd_pop) begin
					case (cmd.kind)
						K_CLEAR: out_push = 1'b1;
						K_BAD: begin
							out_push        = 1'b1;
							out_data.status = ST_BAD;
						end
						K_DRAIN: begin
							out_push        = (fill_in == '0);
							out_data.status = ST_EMPTY;
						end
						default: ;
					endcase
				end
			end
			DRD: begin
				rd_en   = 1'b1;
				rd_addr = base_q + SW'(i_q);
			end
			DOUT: begin
				out_push             = !out_full;
				out_data.entry_count = 32'(cnt_rd_q);
				out_data.last_entry  = (i_q + 1'b1 == fcur_q);
			end
			SRD: rd_en = 1'b1;
			HIT, INS: begin
				out_push             = !out_full;
				wr_en                = !out_full;
				wr_key               = cmd_q.key;
				out_data.entry_count = 32'(new_cnt);
			end
			MISS: begin
				out_push        = !out_full && (fcur_q == FW'(ENTRIES));
				out_data.status = ST_FULL;
			end
			SHRD: begin
				rd_en   = 1'b1;
				rd_addr = base_q + SW'(i_q - 1'b1);
			end
			SHWR: begin
				wr_en   = 1'b1;
				wr_addr = base_q + SW'(i_q);
				wr_cnt  = cnt_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cmd_q   <= '0;
			tbl_q   <= '0;
			base_q  <= '0;
			fcur_q  <= '0;
			pos_q   <= '0;
			i_q     <= '0;
			for (int t = 0; t < COMBINATIONS; t++) begin
				fill_q[t] <= '0;
			end
		end else begin
			case (state_q)
				IDLE: begin
					if (cmd_pop) begin
						cmd_q  <= cmd;
						tbl_q  <= tbl_in;
						base_q <= SW'(tbl_in) * SW'(ENTRIES);
						fcur_q <= fill_in;
						pos_q  <= '0;
						i_q    <= '0;
						case (cmd.kind)
							K_CLEAR: begin
								for (int t = 0; t < COMBINATIONS; t++) begin
									fill_q[t] <= '0;
								end
							end
							K_DRAIN: if (fill_in != '0) state_q <= DRD;
							K_ACCUM: state_q <= (fill_in == '0) ? MISS : SRD;
							default: ;
						endcase
					end
				end
				DRD: state_q <= DOUT;
				DOUT: begin
					if (!out_full) begin
						i_q     <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == fcur_q) ? IDLE : DRD;
					end
				end
				SRD: state_q <= SCMP;
				SCMP: begin
					if (key_rd_q == cmd_q.key) begin
						state_q <= HIT;
					end else if (key_rd_q < cmd_q.key) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= (pos_q + 1'b1 == fcur_q) ? MISS : SRD;
					end else begin
						state_q <= MISS;
					end
				end
				HIT: if (!out_full) state_q <= IDLE;
				MISS: begin
					if (fcur_q == FW'(ENTRIES)) begin
						if (!out_full) state_q <= IDLE;
					end else begin
						i_q     <= fcur_q;
						state_q <= (fcur_q == pos_q) ? INS : SHRD;
					end
				end
				SHRD: state_q <= SHWR;
				SHWR: begin
					i_q     <= i_q - 1'b1;
					state_q <= (i_q - 1'b1 == pos_q) ? INS : SHRD;
				end
				INS: begin
					if (!out_full) begin
						fill_q[tbl_q] <= fcur_q + 1'b1;
						state_q       <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/koc_checker.sv
`default_nettype none
module koc_checker import koc_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    full,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not empty in reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.last_entry |-> result.status == ST_OK)
		else $error("non-final result with error status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_OK |-> result.entry_count == '0 &&
		result.last_entry)
		else $error("error result carries a count");
endmodule

bind keyed_occurrence_counter koc_checker u_koc_checker (
	.clk(clk), .arst_n(arst_n), .full(full), .empty(empty), .pop(pop),
	.result(result)
);
`default_nettype wire
